[sv/rgbpal_pkg.sv]
// Shared types, constants and helper functions for the RGB to palette index converter.
`timescale 1ns / 1ps
package rgbpal_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned IndexW = 8;

  // Channel rounding to a nibble: (x * NibMul + NibBias) >> 12
  localparam logic [7:0]  NibMul  = 8'd241;
  localparam logic [15:0] NibBias = 16'd2048;

  // Divide-by-three of a nibble: (v * Div3Mul) >> 5
  localparam logic [3:0] Div3Mul = 4'd11;

  // Grey level from the channel sum: (sum * GreyMul + GreyBias) >> 6
  localparam logic [4:0] GreyMul  = 5'd21;
  localparam logic [9:0] GreyBias = 10'd36;

  // Palette layout
  localparam logic [7:0] CubeTop   = 8'd215;
  localparam logic [7:0] RedTop    = 8'd225;
  localparam logic [7:0] GreenTop  = 8'd235;
  localparam logic [7:0] BlueTop   = 8'd245;
  localparam logic [7:0] BlackIdx  = 8'd255;
  localparam logic [7:0] WhiteIdx  = 8'd0;
  localparam logic [5:0] WeightR   = 6'd36;
  localparam logic [5:0] WeightG   = 6'd6;
  localparam logic [5:0] WeightB   = 6'd1;
  localparam logic [5:0] WeightDiag = 6'd43;
  localparam logic [2:0] TopLevel  = 3'd5;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [2:0] q;
    logic [1:0] m;
  } div3_t;

  function automatic logic [NibW-1:0] nib_of(input logic [ChanW-1:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'(NibMul) + NibBias;
    return p[15:12];
  endfunction

  function automatic div3_t split3(input logic [3:0] v);
    logic [7:0] p;
    div3_t      d;
    p   = 8'(v) * 8'(Div3Mul);
    d.q = p[7:5];
    d.m = 2'(v - 4'(d.q) * 4'd3);
    return d;
  endfunction

  function automatic logic [IndexW-1:0] ramp_or_cube(input logic [3:0] n,
                                                      input logic [5:0] weight,
                                                      input logic [7:0] ramp_top);
    div3_t d;
    d = split3(n);
    if (d.m == 2'd0) begin
      if (d.q == 3'd0) return BlackIdx;
      return CubeTop - 8'(d.q) * 8'(weight);
    end
    return ramp_top - 8'(d.q) * 8'd2 - 8'(d.m);
  endfunction

endpackage

[sv/rgbpal_map.sv]
// Combinational mapping of one registered pixel to its palette index.
`timescale 1ns / 1ps
module rgbpal_map (
  input  rgbpal_pkg::pix_t   pix,
  output logic [7:0]         palette_index
);
  import rgbpal_pkg::*;

  logic [NibW-1:0] r, g, b;
  logic            r_lo, g_lo, b_lo;
  logic [5:0]      sum;
  logic signed [6:0] dr, dg, db;
  logic            near_grey;
  logic [9:0]      grey_acc;
  logic [3:0]      grey_lvl;
  div3_t           grey_d;
  logic [7:0]      r6p, g6p, b6p;
  logic [2:0]      r6, g6, b6;

  assign r = nib_of(pix.red);
  assign g = nib_of(pix.green);
  assign b = nib_of(pix.blue);

  assign r_lo = (r <= 4'd1);
  assign g_lo = (g <= 4'd1);
  assign b_lo = (b <= 4'd1);

  assign sum = 6'(r) + 6'(g) + 6'(b);
  assign dr  = $signed({1'b0, 6'(r) * 6'd3}) - $signed({1'b0, sum});
  assign dg  = $signed({1'b0, 6'(g) * 6'd3}) - $signed({1'b0, sum});
  assign db  = $signed({1'b0, 6'(b) * 6'd3}) - $signed({1'b0, sum});

  assign near_grey = (dr >= -7'sd3) && (dr <= 7'sd3) &&
                     (dg >= -7'sd3) && (dg <= 7'sd3) &&
                     (db >= -7'sd3) && (db <= 7'sd3);

  assign grey_acc = 10'(sum) * 10'(GreyMul) + GreyBias;
  assign grey_lvl = grey_acc[9:6];
  assign grey_d   = split3(grey_lvl);

  // nearest cube level 0..5 per channel
  assign r6p = 8'(r) * 8'd11 + 8'd11;
  assign g6p = 8'(g) * 8'd11 + 8'd11;
  assign b6p = 8'(b) * 8'd11 + 8'd11;
  assign r6  = r6p[7:5];
  assign g6  = g6p[7:5];
  assign b6  = b6p[7:5];

  always_comb begin
    if (g_lo && b_lo) begin
      if (r_lo) begin
        palette_index = BlackIdx - 8'(b);
      end else begin
        palette_index = ramp_or_cube(r, WeightR, RedTop);
      end
    end else if (r_lo && b_lo) begin
      palette_index = ramp_or_cube(g, WeightG, GreenTop);
    end else if (r_lo && g_lo) begin
      palette_index = ramp_or_cube(b, WeightB, BlueTop);
    end else if (near_grey) begin
      if (grey_d.m == 2'd0) begin
        if (grey_d.q == 3'd0) begin
          palette_index = BlackIdx;
        end else if (grey_d.q == TopLevel) begin
          palette_index = WhiteIdx;
        end else begin
          palette_index = CubeTop - 8'(grey_d.q) * 8'(WeightDiag);
        end
      end else begin
        palette_index = BlackIdx - 8'(grey_d.q) * 8'd2 - 8'(grey_d.m);
      end
    end else if ((r6 | g6 | b6) == 3'd0) begin
      palette_index = BlackIdx;
    end else begin
      palette_index = CubeTop - 8'(b6) - 8'(g6) * 8'(WeightG) - 8'(r6) * 8'(WeightR);
    end
  end

endmodule

[sv/rgb_to_standard_palette_index.sv]
// Top level: input register, palette mapping logic and output register.
`timescale 1ns / 1ps
// Converts a stream of 24-bit RGB pixels into indices of the fixed 256-entry
// standard palette (6x6x6 cube, red/green/blue/grey ramps, black at 255).
// One pixel is taken per clock while the output side does not stall; a pixel
// is captured in the input register on its transfer and moves on to the result
// register when the result register is free or being taken. The two-stage
// pipeline (input register, then result register) keeps flowing as long as
// out_tready is high, and either stage may fill while the result waits.
module rgb_to_standard_palette_index (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata    // palette_index [7:0]
);
  import rgbpal_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  pix_t       s1_pix_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_index_r;
  logic [7:0] map_index;
  logic       s2_ready;
  logic       s1_move;

  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign s1_move   = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pix_r <= pix_t'(in_tdata);
    end
    if (s1_move) begin
      out_index_r <= map_index;
    end
  end

  rgbpal_map u_map (
    .pix           (s1_pix_r),
    .palette_index (map_index)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_index_r;

endmodule

[sv/rgbpal_checker.sv]
// Port-level checks for the palette index converter, bound to the top level.
`timescale 1ns / 1ps
module rgbpal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // an open output side never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input blocked with output free");

  // a transfer is on the output after passing both registers when not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing after transfer");

  // black input maps to the black entry
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata == 24'h0) ##1 out_tready |=>
      out_tdata == 8'hFF)
    else $error("black pixel mapped wrong");

endmodule

bind rgb_to_standard_palette_index rgbpal_checker u_rgbpal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
